/* design/rsf_pkg.sv */
// shared types and constants for the ray sphere far clip datapath
package rsf_pkg;

  localparam int COORD_W  = 32;
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 14;
  localparam int RAD_W    = 31;
  localparam int T8_W     = 35;
  localparam int ROOT_W   = 36;
  localparam int H2_W     = 2 * ROOT_W;
  localparam int IDX_W    = $clog2(ROOT_W);
  localparam int FRONT_STAGES = 7;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY  = FRONT_STAGES + ROOT_W + BACK_STAGES;

  localparam logic ADDR_RADIUS = 1'b0;

  // transaction state handed from one root cell to the next
  typedef struct packed {
    logic                          valid;
    logic                          hit;
    logic [T8_W-1:0]               t8;
    logic [H2_W-1:0]               rem;
    logic [ROOT_W-1:0]             root;
    logic [2:0][COORD_W-1:0]       org;
    logic [2:0][DIR_W-1:0]         dir;
  } cell_t;

endpackage

/* design/ray_sphere_far_clip_top.sv */
// ray to sphere far intersection, top level with register port
// Takes one transaction every clock cycle (busy stays low) and returns each result,
// flagged by a one-cycle done strobe that cannot be held off.
// The pipeline is 7 front stages, then one root cell per bit of the 36-bit square root,
// then 3 stages of scaling and saturation. The radius register at byte address 0
// must only be written while no transaction is in flight.
module ray_sphere_far_clip_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           origin_x,
  input  logic signed [31:0]           origin_y,
  input  logic signed [31:0]           origin_z,
  input  logic signed [15:0]           dir_x,
  input  logic signed [15:0]           dir_y,
  input  logic signed [15:0]           dir_z,
  input  logic signed [31:0]           center_x,
  input  logic signed [31:0]           center_y,
  input  logic signed [31:0]           center_z,
  output logic                         done,
  output logic                         hit,
  output logic signed [31:0]           point_x,
  output logic signed [31:0]           point_y,
  output logic signed [31:0]           point_z
);

  logic [rsf_pkg::RAD_W-1:0]           sphere_radius;
  rsf_pkg::cell_t                      chain [rsf_pkg::ROOT_W+1];
  logic [2:0][rsf_pkg::COORD_W-1:0]    point;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rsf_pkg::ADDR_RADIUS) ? {1'b0, sphere_radius} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= '0;
    end else if (psel && penable && pwrite && paddr[2] == rsf_pkg::ADDR_RADIUS) begin
      sphere_radius <= pwdata[rsf_pkg::RAD_W-1:0];
    end
  end

  // fully pipelined, never stalls
  assign busy = 1'b0;

  rsf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .radius (sphere_radius),
    .org_in ({origin_z, origin_y, origin_x}),
    .dir_in ({dir_z, dir_y, dir_x}),
    .ctr_in ({center_z, center_y, center_x}),
    .out    (chain[0])
  );

  // square root chain, most significant bit first
  for (genvar k = 0; k < rsf_pkg::ROOT_W; k++) begin : g_root
    rsf_root_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bit_idx (rsf_pkg::IDX_W'(rsf_pkg::ROOT_W - 1 - k)),
      .din     (chain[k]),
      .dout    (chain[k+1])
    );
  end

  rsf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .din   (chain[rsf_pkg::ROOT_W]),
    .done  (done),
    .hit   (hit),
    .point (point)
  );

  assign point_x = point[0];
  assign point_y = point[1];
  assign point_z = point[2];

  // every accepted transaction returns after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(rsf_pkg::LATENCY) done)
    else $error("result strobe missing after fixed latency");

  // a miss reports a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> point_x == 0 && point_y == 0 && point_z == 0)
    else $error("miss with nonzero point");

endmodule

/* design/rsf_front.sv */
// geometry front end: projection, distances and the radicand
module rsf_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [rsf_pkg::RAD_W-1:0]              radius,
  input  logic [2:0][rsf_pkg::COORD_W-1:0]       org_in,
  input  logic [2:0][rsf_pkg::DIR_W-1:0]         dir_in,
  input  logic [2:0][rsf_pkg::COORD_W-1:0]       ctr_in,
  output rsf_pkg::cell_t                         out
);

  // stage 1: center minus origin
  logic                                  v1;
  logic [2:0][rsf_pkg::COORD_W:0]        vec1;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org1;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir1;
  // stage 2: products and squares
  logic                                  v2;
  logic [2:0][48:0]                      prod2;
  logic [2:0][63:0]                      sq2;
  logic [61:0]                           rr2;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org2;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir2;
  // stage 3: sums
  logic                                  v3;
  logic signed [50:0]                    t22_3;
  logic [65:0]                           dd3;
  logic [61:0]                           rr3;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org3;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir3;
  // stage 4: partial products of t squared
  logic                                  v4;
  logic                                  neg4;
  logic [rsf_pkg::T8_W-1:0]              t8_4;
  logic [63:0]                           pll4;
  logic [34:0]                           phl4;
  logic [65:0]                           dd4;
  logic [61:0]                           rr4;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org4;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir4;
  // stage 5: half sums of the limit
  logic                                  v5;
  logic                                  neg5;
  logic [rsf_pkg::T8_W-1:0]              t8_5;
  logic [rsf_pkg::H2_W-1:0]              lima5;
  logic [rsf_pkg::H2_W-1:0]              limb5;
  logic [65:0]                           dd5;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org5;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir5;
  // stage 6: limit
  logic                                  v6;
  logic                                  neg6;
  logic [rsf_pkg::T8_W-1:0]              t8_6;
  logic [rsf_pkg::H2_W-1:0]              lim6;
  logic [65:0]                           dd6;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org6;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir6;

  logic [rsf_pkg::H2_W:0]                diff;
  logic [2:0][rsf_pkg::COORD_W-1:0]      vabs;
  logic [2:0]                            hi_t;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out.valid <= v6;
    end
  end

  // magnitudes of the center offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vabs[i] = vec1[i][rsf_pkg::COORD_W] ?
                rsf_pkg::COORD_W'(-$signed(vec1[i])) : vec1[i][rsf_pkg::COORD_W-1:0];
    end
  end

  assign hi_t = t8_4[rsf_pkg::T8_W-1:32];
  assign diff = {1'b0, lim6} - (rsf_pkg::H2_W + 1)'(dd6);

  // datapath registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vec1[i] <= ($signed({ctr_in[i][rsf_pkg::COORD_W-1], ctr_in[i]})
                 - $signed({org_in[i][rsf_pkg::COORD_W-1], org_in[i]}));
      prod2[i] <= 49'($signed(vec1[i]) * $signed(dir1[i]));
      sq2[i]   <= 64'(vabs[i]) * 64'(vabs[i]);
    end
    org1 <= org_in;
    dir1 <= dir_in;

    rr2  <= 62'(radius) * 62'(radius);
    org2 <= org1;
    dir2 <= dir1;

    t22_3 <= 51'($signed(prod2[0])) + 51'($signed(prod2[1])) + 51'($signed(prod2[2]));
    dd3   <= 66'(sq2[0]) + 66'(sq2[1]) + 66'(sq2[2]);
    rr3   <= rr2;
    org3  <= org2;
    dir3  <= dir2;

    neg4 <= t22_3[50];
    t8_4 <= t22_3[rsf_pkg::DIR_FRAC +: rsf_pkg::T8_W];
    pll4 <= 64'(t22_3[rsf_pkg::DIR_FRAC +: 32]) * 64'(t22_3[rsf_pkg::DIR_FRAC +: 32]);
    phl4 <= 35'(t22_3[rsf_pkg::DIR_FRAC+32 +: 3]) * 35'(t22_3[rsf_pkg::DIR_FRAC +: 32]);
    dd4  <= dd3;
    rr4  <= rr3;
    org4 <= org3;
    dir4 <= dir3;

    neg5  <= neg4;
    t8_5  <= t8_4;
    lima5 <= rsf_pkg::H2_W'(pll4) + rsf_pkg::H2_W'(rr4);
    limb5 <= (rsf_pkg::H2_W'(6'(hi_t) * 6'(hi_t)) << 64) + (rsf_pkg::H2_W'(phl4) << 33);
    dd5   <= dd4;
    org5  <= org4;
    dir5  <= dir4;

    neg6 <= neg5;
    t8_6 <= t8_5;
    lim6 <= lima5 + limb5;
    dd6  <= dd5;
    org6 <= org5;
    dir6 <= dir5;

    out.hit  <= !neg6 && !diff[rsf_pkg::H2_W];
    out.t8   <= t8_6;
    out.rem  <= (!neg6 && !diff[rsf_pkg::H2_W]) ? diff[rsf_pkg::H2_W-1:0] : '0;
    out.root <= '0;
    out.org  <= org6;
    out.dir  <= dir6;
  end

endmodule

/* design/rsf_root_cell.sv */
// one digit of the square root, restoring form
module rsf_root_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rsf_pkg::IDX_W-1:0]    bit_idx,
  input  rsf_pkg::cell_t               din,
  output rsf_pkg::cell_t               dout
);

  logic [rsf_pkg::H2_W-1:0] trial;
  logic                     take;

  // (2*root + 2^b) * 2^b
  assign trial = (rsf_pkg::H2_W'(din.root) << (bit_idx + 1'b1))
               + (rsf_pkg::H2_W'(1) << {bit_idx, 1'b0});
  assign take  = din.rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.hit  <= din.hit;
    dout.t8   <= din.t8;
    dout.org  <= din.org;
    dout.dir  <= din.dir;
    dout.rem  <= take ? din.rem - trial : din.rem;
    dout.root <= take ? din.root | (rsf_pkg::ROOT_W'(1) << bit_idx) : din.root;
  end

endmodule

/* design/rsf_back.sv */
// scale the direction by the far distance, add origin, saturate
module rsf_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rsf_pkg::cell_t                        din,
  output logic                                  done,
  output logic                                  hit,
  output logic [2:0][rsf_pkg::COORD_W-1:0]      point
);

  logic                                  v1;
  logic                                  hit1;
  logic [rsf_pkg::ROOT_W:0]              s1;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org1;
  logic [2:0][rsf_pkg::DIR_W-1:0]        dir1;
  logic                                  v2;
  logic                                  hit2;
  logic [2:0][53:0]                      m2;
  logic [2:0][rsf_pkg::COORD_W-1:0]      org2;
  logic [2:0][rsf_pkg::COORD_W-1:0]      sat;
  logic signed [2:0][40:0]               sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= din.valid;
      v2   <= v1;
      done <= v2;
    end
  end

  // floor shift, origin add and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 41'($signed(m2[i][53:rsf_pkg::DIR_FRAC])) + 41'($signed(org2[i]));
      if ($signed(sum[i]) > 41'sd2147483647) begin
        sat[i] = 32'h7fffffff;
      end else if ($signed(sum[i]) < -41'sd2147483648) begin
        sat[i] = 32'h80000000;
      end else begin
        sat[i] = sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit1 <= din.hit;
    s1   <= (rsf_pkg::ROOT_W + 1)'(din.t8) + (rsf_pkg::ROOT_W + 1)'(din.root);
    org1 <= din.org;
    dir1 <= din.dir;
    hit2 <= hit1;
    org2 <= org1;
    for (int i = 0; i < 3; i++) begin
      m2[i] <= 54'($signed({1'b0, s1}) * $signed(dir1[i]));
      point[i] <= hit2 ? sat[i] : '0;
    end
    hit <= hit2;
  end

endmodule
